@@ sv/i2cdbw_pkg.sv @@
// shared types and constants for the i2c display byte writer
`timescale 1ns / 1ps

package i2cdbw_pkg;

    // frame layout
    localparam int BYTES_PER_FRAME = 3;
    // address, control and payload bytes; bytes past the third shift in as zero
    localparam int SHIFT_W         = 24;
    localparam int BYTE_CNT_W      = (BYTES_PER_FRAME > 1) ? $clog2(BYTES_PER_FRAME) : 1;
    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(BYTES_PER_FRAME - 1);
    localparam logic [BYTE_CNT_W-1:0] BYTE_STEP = BYTE_CNT_W'(1);

    // bit counter value that marks the ack clock
    localparam logic [3:0] ACK_BIT = 4'd8;

    // operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_DATA    = 2'd2;

    // register indexes and reset values
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_DEVICE_ADDR = 2'd0;
    localparam logic [1:0] REG_CMD_CTRL    = 2'd1;
    localparam logic [1:0] REG_DATA_CTRL   = 2'd2;
    localparam logic [7:0] DEVICE_ADDR_RST = 8'h78;
    localparam logic [7:0] CMD_CTRL_RST    = 8'h00;
    localparam logic [7:0] DATA_CTRL_RST   = 8'h40;

    // frame sequencer phases
    typedef enum logic [1:0] {
        PH_START,
        PH_BYTE,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] payload_byte;
    } req_item_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy_res;
        logic request_accepted;
        logic frame_done;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0] device_write_address;
        logic [7:0] command_control_byte;
        logic [7:0] data_control_byte;
    } cfg_t;

endpackage

@@ sv/i2cdbw_cfg_regs.sv @@
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module i2cdbw_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cdbw_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output i2cdbw_pkg::cfg_t               cfg
);

    i2cdbw_pkg::cfg_t cfg_reg;
    i2cdbw_pkg::cfg_t cfg_next;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                i2cdbw_pkg::REG_DEVICE_ADDR: cfg_next.device_write_address = pwdata[7:0];
                i2cdbw_pkg::REG_CMD_CTRL:    cfg_next.command_control_byte = pwdata[7:0];
                i2cdbw_pkg::REG_DATA_CTRL:   cfg_next.data_control_byte    = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_write_address <= i2cdbw_pkg::DEVICE_ADDR_RST;
            cfg_reg.command_control_byte <= i2cdbw_pkg::CMD_CTRL_RST;
            cfg_reg.data_control_byte    <= i2cdbw_pkg::DATA_CTRL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            i2cdbw_pkg::REG_DEVICE_ADDR: prdata = {24'd0, cfg_reg.device_write_address};
            i2cdbw_pkg::REG_CMD_CTRL:    prdata = {24'd0, cfg_reg.command_control_byte};
            i2cdbw_pkg::REG_DATA_CTRL:   prdata = {24'd0, cfg_reg.data_control_byte};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/i2cdbw_sequencer.sv @@
// frame sequencer: one pin step per tick, start/bytes/ack/stop
`timescale 1ns / 1ps

module i2cdbw_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  i2cdbw_pkg::req_item_t  req,
    input  i2cdbw_pkg::cfg_t       cfg,
    output i2cdbw_pkg::rsp_item_t  result
);

    i2cdbw_pkg::phase_t                   phase_reg, phase_next;
    logic [1:0]                           sub_reg, sub_next;
    logic [3:0]                           bit_reg, bit_next;
    logic [i2cdbw_pkg::BYTE_CNT_W-1:0]    byte_reg, byte_next;
    logic [i2cdbw_pkg::SHIFT_W-1:0]       shift_reg, shift_next;
    logic                                 active_reg, active_next;
    logic                                 scl_reg, scl_next;
    logic                                 sda_reg, sda_next;
    logic                                 accepted;
    logic                                 done;
    logic                                 is_tick;
    logic                                 is_req;
    logic [7:0]                           ctrl_byte;

    assign is_tick   = (req.operation == i2cdbw_pkg::OP_TICK);
    assign is_req    = (req.operation == i2cdbw_pkg::OP_COMMAND) ||
                       (req.operation == i2cdbw_pkg::OP_DATA);
    assign ctrl_byte = (req.operation == i2cdbw_pkg::OP_COMMAND) ?
                       cfg.command_control_byte : cfg.data_control_byte;

    // next state for one request
    always_comb
    begin
        phase_next  = phase_reg;
        sub_next    = sub_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        shift_next  = shift_reg;
        active_next = active_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        accepted    = 1'b0;
        done        = 1'b0;

        if (is_req && !active_reg)
        begin
            // new frame: load address, control and payload bytes
            shift_next  = {cfg.device_write_address, ctrl_byte, req.payload_byte};
            phase_next  = i2cdbw_pkg::PH_START;
            sub_next    = 2'd0;
            bit_next    = 4'd0;
            byte_next   = '0;
            active_next = 1'b1;
            accepted    = 1'b1;
        end
        else if (is_tick && active_reg)
        begin
            case (phase_reg)
                i2cdbw_pkg::PH_START:
                begin
                    sub_next = sub_reg + 2'd1;
                    case (sub_reg)
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default:
                        begin
                            scl_next   = 1'b0;
                            phase_next = i2cdbw_pkg::PH_BYTE;
                            sub_next   = 2'd0;
                            bit_next   = 4'd0;
                            byte_next  = '0;
                        end
                    endcase
                end
                i2cdbw_pkg::PH_BYTE:
                begin
                    if (bit_reg != i2cdbw_pkg::ACK_BIT)
                    begin
                        // data bit: set sda, raise scl, drop scl
                        case (sub_reg)
                            2'd0:
                            begin
                                sda_next   = shift_reg[i2cdbw_pkg::SHIFT_W-1];
                                shift_next = {shift_reg[i2cdbw_pkg::SHIFT_W-2:0], 1'b0};
                                sub_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                scl_next = 1'b1;
                                sub_next = 2'd2;
                            end
                            default:
                            begin
                                scl_next = 1'b0;
                                sub_next = 2'd0;
                                bit_next = bit_reg + 4'd1;
                            end
                        endcase
                    end
                    else
                    begin
                        // ack clock, not sampled
                        if (sub_reg == 2'd0)
                        begin
                            scl_next = 1'b1;
                            sub_next = 2'd1;
                        end
                        else
                        begin
                            scl_next = 1'b0;
                            sub_next = 2'd0;
                            bit_next = 4'd0;
                            if (byte_reg == i2cdbw_pkg::LAST_BYTE)
                            begin
                                phase_next = i2cdbw_pkg::PH_STOP;
                            end
                            else
                            begin
                                byte_next = byte_reg + i2cdbw_pkg::BYTE_STEP;
                            end
                        end
                    end
                end
                i2cdbw_pkg::PH_STOP:
                begin
                    case (sub_reg)
                        2'd0:
                        begin
                            sda_next = 1'b0;
                            sub_next = 2'd1;
                        end
                        2'd1:
                        begin
                            scl_next = 1'b1;
                            sub_next = 2'd2;
                        end
                        default:
                        begin
                            sda_next    = 1'b1;
                            sub_next    = 2'd0;
                            active_next = 1'b0;
                            phase_next  = i2cdbw_pkg::PH_START;
                            done        = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = i2cdbw_pkg::PH_START;
                end
            endcase
        end
    end

    // result fields follow the state after this request
    always_comb
    begin
        result.scl_level        = scl_next;
        result.sda_level        = sda_next;
        result.busy_res         = active_next;
        result.request_accepted = accepted;
        result.frame_done       = done;
    end

    // control and pin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= i2cdbw_pkg::PH_START;
            sub_reg    <= 2'd0;
            bit_reg    <= 4'd0;
            byte_reg   <= '0;
            active_reg <= 1'b0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            sub_reg    <= sub_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            active_reg <= active_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
        end
    end

    // frame shift register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

@@ sv/i2c_display_byte_writer.sv @@
// top level of the i2c display byte writer
`timescale 1ns / 1ps
// Usage
// - req channel (req_valid/req_ready/req): operation is a tick (one pin
//   step), a command request or a data request; payload_byte is the byte to
//   send on a request.
// - A request while idle loads address, control and payload bytes and starts
//   a frame; each later tick takes one pin step. A request while busy is
//   refused (request_accepted 0). A frame takes 7 + 26 * BYTES_PER_FRAME ticks.
// - rsp channel (rsp_valid/rsp_ready/rsp): one response per request with
//   the scl/sda levels, busy flag, accept flag and frame done flag.
// - Latency: the response is valid the cycle after the request is taken.
//   Throughput: one request per cycle while each response is taken, set by
//   the single-step sequencer and the one-entry response register.
// - When the receiver stalls, the response register holds its value and
//   req_ready drops until the response is taken.
// - Reset: pins released high, sequencer idle, registers at their defaults,
//   no response pending.
// - Config: APB-style registers at 0x0 (device address), 0x4 (command
//   control byte), 0x8 (data control byte); write only while idle.

module i2c_display_byte_writer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  i2cdbw_pkg::req_item_t          req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output i2cdbw_pkg::rsp_item_t          rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cdbw_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    i2cdbw_pkg::cfg_t       cfg;
    i2cdbw_pkg::rsp_item_t  result;
    i2cdbw_pkg::rsp_item_t  rsp_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic                   req_take;

    // request handshake
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_take  = req_valid && req_ready;

    i2cdbw_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cdbw_sequencer u_sequencer (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (req_take),
        .req     (req),
        .cfg     (cfg),
        .result  (result)
    );

    // response valid tracking
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (req_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload register
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ sim/i2c_display_byte_writer_tb.sv @@
// testbench for the i2c display byte writer: directed table plus random frames
`timescale 1ns / 1ps

module i2c_display_byte_writer_tb;

    // operation code with no meaning to the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // ticks in one frame and the step that opens the stop condition
    localparam int FRAME_TICKS    = 7 + 26 * i2cdbw_pkg::BYTES_PER_FRAME;
    localparam int STOP_STEP      = 4 + 26 * i2cdbw_pkg::BYTES_PER_FRAME;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_PERIODIC,
        RDY_SPARSE
    } ready_mode_t;

    typedef struct {
        row_kind_t             kind;
        i2cdbw_pkg::req_item_t item;
        int                    reps;
        bit                    pinned;
        i2cdbw_pkg::rsp_item_t want;
        logic [1:0]            reg_idx;
        logic [7:0]            reg_val;
    } stim_row_t;

    // dut ports
    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             req_valid = 1'b0;
    logic                             req_ready;
    i2cdbw_pkg::req_item_t            req       = '0;
    logic                             rsp_valid;
    logic                             rsp_ready = 1'b0;
    i2cdbw_pkg::rsp_item_t            rsp;
    logic                             psel      = 1'b0;
    logic                             penable   = 1'b0;
    logic                             pwrite    = 1'b0;
    logic [i2cdbw_pkg::ADDR_W-1:0]    paddr     = '0;
    logic [31:0]                      pwdata    = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    // typed expectation that travels with a directed request
    bit                    req_pinned     = 1'b0;
    i2cdbw_pkg::rsp_item_t req_pinned_rsp = '0;

    // register shadow and pin sequencer model
    i2cdbw_pkg::cfg_t shadow_cfg = '{i2cdbw_pkg::DEVICE_ADDR_RST,
                                     i2cdbw_pkg::CMD_CTRL_RST,
                                     i2cdbw_pkg::DATA_CTRL_RST};
    logic [6:0]  frame_step  = '0;
    logic [23:0] frame_bits  = '0;
    logic        scl_pin     = 1'b1;
    logic        sda_pin     = 1'b1;
    logic        in_frame    = 1'b0;

    i2cdbw_pkg::rsp_item_t pending_rsp[$];
    stim_row_t             plan[$];
    int                    errors      = 0;
    int                    burst_left  = 0;
    int                    idle_cycles = 0;
    int                    ready_left  = 0;
    int                    ready_count = 0;
    ready_mode_t           ready_mode  = RDY_ALWAYS;

    i2c_display_byte_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one request through the writer model: pin step, frame start or nothing
    function automatic i2cdbw_pkg::rsp_item_t advance_writer(input i2cdbw_pkg::req_item_t r);
        i2cdbw_pkg::rsp_item_t o;
        int                    s;
        int                    p;
        bit                    last;
        o    = '0;
        last = 1'b0;
        case (r.operation)
            i2cdbw_pkg::OP_TICK:
            begin
                if (in_frame)
                begin
                    s = frame_step;
                    if (s < 4)
                    begin
                        // start condition
                        case (s)
                            0:       sda_pin = 1'b1;
                            1:       scl_pin = 1'b1;
                            2:       sda_pin = 1'b0;
                            default: scl_pin = 1'b0;
                        endcase
                    end
                    else if (s < STOP_STEP)
                    begin
                        // eight data bits, msb first, then the unsampled ack clock
                        p = (s - 4) % 26;
                        if (p < 24)
                        begin
                            if (p % 3 == 0)
                            begin
                                sda_pin    = frame_bits[23];
                                frame_bits = frame_bits << 1;
                            end
                            else
                                scl_pin = (p % 3 == 1);
                        end
                        else
                            scl_pin = (p == 24);
                    end
                    else
                    begin
                        // stop condition
                        case (s - STOP_STEP)
                            0:       sda_pin = 1'b0;
                            1:       scl_pin = 1'b1;
                            default:
                            begin
                                sda_pin = 1'b1;
                                last    = 1'b1;
                            end
                        endcase
                    end
                    if (last)
                    begin
                        in_frame     = 1'b0;
                        frame_step   = '0;
                        o.frame_done = 1'b1;
                    end
                    else
                        frame_step = frame_step + 7'd1;
                end
            end
            i2cdbw_pkg::OP_COMMAND, i2cdbw_pkg::OP_DATA:
            begin
                if (!in_frame)
                begin
                    frame_bits = {shadow_cfg.device_write_address,
                                  (r.operation == i2cdbw_pkg::OP_COMMAND)
                                      ? shadow_cfg.command_control_byte
                                      : shadow_cfg.data_control_byte,
                                  r.payload_byte};
                    frame_step         = '0;
                    in_frame           = 1'b1;
                    o.request_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        o.scl_level = scl_pin;
        o.sda_level = sda_pin;
        o.busy_res  = in_frame;
        return o;
    endfunction

    // byte values leaning on the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // directed table builders
    function automatic void add_item(input logic [1:0] op, input logic [7:0] val, input int reps);
        stim_row_t row;
        row         = '{kind: ROW_ITEM, default: '0};
        row.item    = '{op, val};
        row.reps    = reps;
        plan.push_back(row);
    endfunction

    function automatic void add_fixed(input logic [1:0] op, input logic [7:0] val,
                                      input i2cdbw_pkg::rsp_item_t want);
        stim_row_t row;
        row         = '{kind: ROW_ITEM, default: '0};
        row.item    = '{op, val};
        row.reps    = 1;
        row.pinned  = 1'b1;
        row.want    = want;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [7:0] val);
        stim_row_t row;
        row         = '{kind: ROW_CFG, default: '0};
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endfunction

    // request sender with bursts and gaps
    task automatic send_item(input i2cdbw_pkg::req_item_t r, input bit pin,
                             input i2cdbw_pkg::rsp_item_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid      <= 1'b1;
        req            <= r;
        req_pinned     <= pin;
        req_pinned_rsp <= want;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic send_req(input i2cdbw_pkg::req_item_t r);
        send_item(r, 1'b0, '0);
    endtask

    // stop sending and wait until every response is back
    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_rsp.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // register write followed by a read back
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, val})
        begin
            $display("%0t: register %0d read back expected %h got %h", $time, idx,
                     {24'd0, val}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            i2cdbw_pkg::REG_DEVICE_ADDR: shadow_cfg.device_write_address = val;
            i2cdbw_pkg::REG_CMD_CTRL:    shadow_cfg.command_control_byte = val;
            i2cdbw_pkg::REG_DATA_CTRL:   shadow_cfg.data_control_byte    = val;
            default: ;
        endcase
        // bus idle before the next transfer
        @(posedge clk);
    endtask

    task automatic shuffle_regs();
        if ($urandom_range(0, 1)) write_reg(i2cdbw_pkg::REG_DEVICE_ADDR, pick_byte());
        if ($urandom_range(0, 1)) write_reg(i2cdbw_pkg::REG_CMD_CTRL, pick_byte());
        if ($urandom_range(0, 1)) write_reg(i2cdbw_pkg::REG_DATA_CTRL, pick_byte());
    endtask

    // response receiver stalls in changing modes
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(50, 300);
        end
        ready_left--;
        ready_count++;
        case (ready_mode)
            RDY_ALWAYS:   rsp_ready <= 1'b1;
            RDY_MOSTLY:   rsp_ready <= ($urandom_range(0, 9) < 7);
            RDY_PERIODIC: rsp_ready <= (ready_count % 5 != 0);
            default:      rsp_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // response check against the oldest expectation, then predict new requests
    always @(posedge clk)
    begin : scoreboard
        i2cdbw_pkg::rsp_item_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response with nothing expected: scl=%b sda=%b busy=%b %s",
                         $time, rsp.scl_level, rsp.sda_level, rsp.busy_res,
                         $sformatf("acc=%b done=%b", rsp.request_accepted,
                                   rsp.frame_done));
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp !== want)
                begin
                    $display("%0t: response mismatch expected %s, got %s", $time,
                             $sformatf("scl=%b sda=%b busy=%b acc=%b done=%b",
                                       want.scl_level, want.sda_level, want.busy_res,
                                       want.request_accepted, want.frame_done),
                             $sformatf("scl=%b sda=%b busy=%b acc=%b done=%b",
                                       rsp.scl_level, rsp.sda_level, rsp.busy_res,
                                       rsp.request_accepted, rsp.frame_done));
                    errors++;
                end
            end
        end
        if (req_valid && req_ready)
        begin
            want = advance_writer(req);
            if (req_pinned)
                want = req_pinned_rsp;
            pending_rsp.push_back(want);
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        i2cdbw_pkg::req_item_t r;
        int                    useful;
        int                    cut_at;
        int                    stop_at;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; fixed responses are {scl, sda, busy, accepted, done}
        add_fixed(i2cdbw_pkg::OP_TICK, 8'h00, 5'b11000);     // tick while idle
        add_fixed(OP_UNUSED, 8'hFF, 5'b11000);               // unused op while idle
        add_fixed(i2cdbw_pkg::OP_COMMAND, 8'hFF, 5'b11110);  // request starts a frame
        add_fixed(i2cdbw_pkg::OP_DATA, 8'h00, 5'b11100);     // request while busy is refused
        add_fixed(OP_UNUSED, 8'h55, 5'b11100);               // unused op while busy, no step
        add_fixed(i2cdbw_pkg::OP_TICK, 8'hAA, 5'b11100);     // start: sda high
        add_fixed(i2cdbw_pkg::OP_TICK, 8'h00, 5'b11100);     // start: scl high
        add_fixed(i2cdbw_pkg::OP_TICK, 8'h00, 5'b10100);     // start: sda low
        add_fixed(i2cdbw_pkg::OP_TICK, 8'h00, 5'b00100);     // start: scl low
        add_item(i2cdbw_pkg::OP_TICK, 8'h00, FRAME_TICKS - 5);
        add_fixed(i2cdbw_pkg::OP_TICK, 8'h00, 5'b11001);     // last stop step
        add_cfg(i2cdbw_pkg::REG_DEVICE_ADDR, 8'hFF);
        add_cfg(i2cdbw_pkg::REG_CMD_CTRL, 8'hFF);
        add_cfg(i2cdbw_pkg::REG_DATA_CTRL, 8'h00);
        add_fixed(i2cdbw_pkg::OP_DATA, 8'h00, 5'b11110);
        add_item(i2cdbw_pkg::OP_TICK, 8'hFF, FRAME_TICKS);
        add_cfg(i2cdbw_pkg::REG_DEVICE_ADDR, 8'h00);
        add_cfg(i2cdbw_pkg::REG_CMD_CTRL, 8'h00);
        add_cfg(i2cdbw_pkg::REG_DATA_CTRL, 8'hFF);
        add_item(i2cdbw_pkg::OP_COMMAND, 8'hFF, 1);
        add_item(i2cdbw_pkg::OP_TICK, 8'h00, 40);
        // register writes in mid frame only reach the next frame
        add_cfg(i2cdbw_pkg::REG_DATA_CTRL, 8'h5A);
        add_cfg(i2cdbw_pkg::REG_DEVICE_ADDR, 8'h3C);
        add_item(i2cdbw_pkg::OP_TICK, 8'h00, FRAME_TICKS - 40);
        add_item(i2cdbw_pkg::OP_DATA, 8'h81, 1);
        add_item(i2cdbw_pkg::OP_TICK, 8'h00, FRAME_TICKS);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                repeat (plan[i].reps) send_item(plan[i].item, plan[i].pinned, plan[i].want);
        end

        // random frames with noise, cut frames and register changes
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                settle();
                shuffle_regs();
            end
            r.operation    = $urandom_range(0, 1) ? i2cdbw_pkg::OP_DATA
                                                  : i2cdbw_pkg::OP_COMMAND;
            r.payload_byte = pick_byte();
            send_req(r);
            useful++;
            cut_at  = ($urandom_range(0, 14) == 0) ? $urandom_range(0, FRAME_TICKS - 1)
                                                    : FRAME_TICKS;
            stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, FRAME_TICKS - 1) : -1;
            for (int k = 0; k < cut_at; k++)
            begin
                if (k == stop_at)
                begin
                    settle();
                    shuffle_regs();
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       r.operation = OP_UNUSED;
                        1:       r.operation = i2cdbw_pkg::OP_COMMAND;
                        default: r.operation = i2cdbw_pkg::OP_DATA;
                    endcase
                    r.payload_byte = pick_byte();
                    send_req(r);
                    if (r.operation != OP_UNUSED)
                        useful++;
                end
                r = '{i2cdbw_pkg::OP_TICK, 8'($urandom_range(0, 255))};
                send_req(r);
                useful++;
            end
            // a few ticks with nothing to do
            repeat ($urandom_range(0, 2)) send_req('{i2cdbw_pkg::OP_TICK, pick_byte()});
        end

        settle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
